[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Every macro samples on the rising edge of clk and is held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the cycle after.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/epct_pkg.sv]
// ----------------------------------------------------------------------------
// epct_pkg
// Request and result types, request kinds and neighbor offsets for the
// edge pixel chain tracker.
// ----------------------------------------------------------------------------
package epct_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE      = 2'd0,
    KIND_TRACK      = 2'd1,
    KIND_READ_POINT = 2'd2,
    KIND_READ_PIXEL = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   row;
    logic [7:0]   col;
    logic         edge_bit;
    logic [10:0]  edge_no;
    logic [11:0]  point_index;
  } in_t;

  typedef struct packed {
    logic [7:0]         point_row;
    logic [7:0]         point_col;
    logic signed [11:0] pixel_value;
    logic [12:0]        edge_length;
    logic               overflow;
  } out_t;

  localparam int PIX_W = 12;
  localparam int PT_W  = 16;

  // Neighbor order: down, right, up, left, down-right, down-left, up-left, up-right.
  localparam logic signed [1:0] NB_DR [8] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                              2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] NB_DC [8] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                              2'sd1, -2'sd1, -2'sd1, 2'sd1};

endpackage

[design/epct_ram.sv]
// ----------------------------------------------------------------------------
// epct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module epct_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/edge_pixel_chain_tracker.sv]
// ----------------------------------------------------------------------------
// edge_pixel_chain_tracker
// Binary edge image store with 8-connected edge linking into a point list.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pixel store to zero, one pixel a cycle, so
// it stalls requests until the whole store is cleared. A pixel write goes
// from idle to the finish state; a point or pixel read first passes a read
// state that captures the registered RAM data. A track request probes one
// neighbor a cycle through the single read port of the pixel store, except
// in the cycle of a hit, where the label write lands; each branch ends once
// all eight neighbors of its last point are probed without a hit. Between
// the two branches the stored first branch is reversed in place, each swap
// passing REV_RL, REV_RH, REV_WL and REV_WH, bounded by the single read and
// write port of the point list. One request is handled at a time; the result
// register lets the next request be accepted while a result waits.
module edge_pixel_chain_tracker #(
  parameter int ROWS        = 256,
  parameter int COLS        = 256,
  parameter int MAX_POINTS  = 4096,
  parameter int EDGE_LABELS = 2048
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  epct_pkg::in_t  in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output epct_pkg::out_t out_res
);
  import epct_pkg::*;

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int NPIX  = ROWS * COLS;
  localparam int AW    = $clog2(NPIX);
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CNT_W = PW + 1;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_RD     = 9'b000000100,
    ST_SCAN   = 9'b000001000,
    ST_REV_RL = 9'b000010000,
    ST_REV_RH = 9'b000100000,
    ST_REV_WL = 9'b001000000,
    ST_REV_WH = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r,
                                           input logic [CW-1:0] c);
    logic [31:0] a;
    a = 32'(r) * 32'(COLS) + 32'(c);
    return a[AW-1:0];
  endfunction

  function automatic logic [PT_W-1:0] pt_of(input logic [RW-1:0] r,
                                           input logic [CW-1:0] c);
    logic [31:0] rr;
    logic [31:0] cc;
    rr = 32'(r);
    cc = 32'(c);
    return {rr[7:0], cc[7:0]};
  endfunction

  state_t state;

  // Clearing sweep
  logic [AW-1:0] clr_addr;

  // Tracking state
  logic [RW-1:0]    cur_r, st_r, pend_r;
  logic [CW-1:0]    cur_c, st_c, pend_c;
  logic [PIX_W-1:0] lab;
  logic [3:0]       probe;
  logic             pend_valid, pend_inb;
  logic             branch;
  logic [CNT_W-1:0] stored;
  logic [CNT_W-1:0] chain_len;
  logic             ovf;
  logic [PW-1:0]    lo, hi;
  logic [PT_W-1:0]  tmp_pt;

  // Read requests and result fields
  logic             rd_pt, rd_px;
  logic [7:0]       res_row, res_col;
  logic [PIX_W-1:0] res_pix;
  logic             res_load;

  // Memory ports
  logic             pix_we;
  logic [AW-1:0]    pix_waddr, pix_raddr;
  logic [PIX_W-1:0] pix_wdata, pix_rdata;
  logic             pl_we;
  logic [PW-1:0]    pl_waddr, pl_raddr;
  logic [PT_W-1:0]  pl_wdata, pl_rdata;

  // Decoded request
  logic             in_take;
  logic [31:0]      row_ext, col_ext, idx_ext;
  logic [RW-1:0]    in_r;
  logic [CW-1:0]    in_c;
  logic             in_inside, eno_ok, idx_ok;
  logic [PIX_W-1:0] in_lab;

  // Neighbor probe
  logic signed [1:0] dr, dc;
  logic [31:0]       nr_sum, nc_sum;
  logic [RW-1:0]     nr;
  logic [CW-1:0]     nc;
  logic              nb_ok;
  logic              hit, room, scan_end;
  logic [CNT_W-1:0]  stored_m1;
  logic [31:0]       cl_ext;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign row_ext   = 32'(in_req.row);
  assign col_ext   = 32'(in_req.col);
  assign idx_ext   = 32'(in_req.point_index);
  assign in_r      = row_ext[RW-1:0];
  assign in_c      = col_ext[CW-1:0];
  assign in_inside = (row_ext < ROWS) && (col_ext < COLS);
  assign eno_ok    = (in_req.edge_no != '0) && (32'(in_req.edge_no) < EDGE_LABELS);
  assign idx_ok    = idx_ext < MAX_POINTS;
  assign in_lab    = 12'd0 - {1'b0, in_req.edge_no};

  // Neighbor of the current point for the probe slot; flag it when it falls off the image.
  assign dr     = NB_DR[probe[2:0]];
  assign dc     = NB_DC[probe[2:0]];
  assign nr_sum = 32'(cur_r) + 32'(dr);
  assign nc_sum = 32'(cur_c) + 32'(dc);
  assign nr     = nr_sum[RW-1:0];
  assign nc     = nc_sum[CW-1:0];
  assign nb_ok  = !((dr == 2'sd1  && cur_r == RW'(ROWS - 1)) ||
                    (dr == -2'sd1 && cur_r == '0) ||
                    (dc == 2'sd1  && cur_c == CW'(COLS - 1)) ||
                    (dc == -2'sd1 && cur_c == '0));

  // A probe answered last cycle finds an unlabeled edge pixel.
  assign hit       = (state == ST_SCAN) && pend_valid && pend_inb && (pix_rdata == 12'd1);
  assign room      = 32'(stored) < MAX_POINTS;
  assign scan_end  = (state == ST_SCAN) && !hit && probe[3] && !pend_valid;
  assign stored_m1 = stored - 1'b1;
  assign cl_ext    = 32'(chain_len);

  // Load the result register when the request is done and the register is free.
  assign res_load  = (state == ST_FINISH) && (!out_valid || !out_stall);

  // Memory port steering
  always_comb begin
    pix_we    = 1'b0;
    pix_waddr = addr_of(in_r, in_c);
    pix_wdata = {{(PIX_W-1){1'b0}}, in_req.edge_bit};
    pix_raddr = addr_of(in_r, in_c);
    pl_we     = 1'b0;
    pl_waddr  = '0;
    pl_wdata  = pt_of(in_r, in_c);
    pl_raddr  = idx_ext[PW-1:0];
    unique case (state)
      ST_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_addr;
        pix_wdata = '0;
      end
      ST_IDLE: begin
        if (in_take && in_inside && in_req.kind == KIND_WRITE) begin
          pix_we = 1'b1;
        end
        if (in_take && in_inside && eno_ok && in_req.kind == KIND_TRACK) begin
          pix_we    = 1'b1;
          pix_wdata = in_lab;
          pl_we     = 1'b1;
        end
      end
      ST_SCAN: begin
        pix_raddr = addr_of(nr, nc);
        if (hit) begin
          pix_we    = 1'b1;
          pix_waddr = addr_of(pend_r, pend_c);
          pix_wdata = lab;
          pl_we     = room;
          pl_waddr  = stored[PW-1:0];
          pl_wdata  = pt_of(pend_r, pend_c);
        end
      end
      ST_REV_RL: pl_raddr = lo;
      ST_REV_RH: pl_raddr = hi;
      ST_REV_WL: begin
        pl_we    = 1'b1;
        pl_waddr = lo;
        pl_wdata = pl_rdata;
      end
      ST_REV_WH: begin
        pl_we    = 1'b1;
        pl_waddr = hi;
        pl_wdata = tmp_pt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      chain_len  <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Raise the result on load; drop it once the consumer takes it.
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(NPIX - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            res_row <= '0;
            res_col <= '0;
            res_pix <= '0;
            rd_pt   <= 1'b0;
            rd_px   <= 1'b0;
            unique case (in_req.kind)
              KIND_WRITE: state <= ST_FINISH;
              KIND_TRACK: begin
                state <= ST_FINISH;
                if (!in_inside) begin
                  chain_len <= '0;
                  ovf       <= 1'b0;
                end else if (eno_ok) begin
                  // Label the start pixel, store it as point zero, then scan.
                  lab        <= in_lab;
                  cur_r      <= in_r;
                  cur_c      <= in_c;
                  st_r       <= in_r;
                  st_c       <= in_c;
                  stored     <= CNT_W'(1);
                  ovf        <= 1'b0;
                  branch     <= 1'b0;
                  probe      <= '0;
                  pend_valid <= 1'b0;
                  state      <= ST_SCAN;
                end
              end
              KIND_READ_POINT: begin
                rd_pt <= idx_ok;
                state <= ST_RD;
              end
              KIND_READ_PIXEL: begin
                rd_px <= in_inside;
                state <= ST_RD;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_RD: begin
          if (rd_pt) begin
            res_row <= pl_rdata[15:8];
            res_col <= pl_rdata[7:0];
          end
          if (rd_px) begin
            res_pix <= pix_rdata;
          end
          state <= ST_FINISH;
        end
        ST_SCAN: begin
          if (hit) begin
            // Advance to the found pixel and restart the neighbor order.
            cur_r      <= pend_r;
            cur_c      <= pend_c;
            probe      <= '0;
            pend_valid <= 1'b0;
            if (room) begin
              stored <= stored + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end else if (!probe[3]) begin
            pend_valid <= 1'b1;
            pend_inb   <= nb_ok;
            pend_r     <= nr;
            pend_c     <= nc;
            probe      <= probe + 1'b1;
          end else if (pend_valid) begin
            pend_valid <= 1'b0;
          end else if (scan_end) begin
            if (branch) begin
              chain_len <= stored;
              state     <= ST_FINISH;
            end else if (stored > CNT_W'(1)) begin
              lo    <= '0;
              hi    <= stored_m1[PW-1:0];
              state <= ST_REV_RL;
            end else begin
              cur_r  <= st_r;
              cur_c  <= st_c;
              probe  <= '0;
              branch <= 1'b1;
            end
          end
        end
        ST_REV_RL: state <= ST_REV_RH;
        ST_REV_RH: begin
          tmp_pt <= pl_rdata;
          state  <= ST_REV_WL;
        end
        ST_REV_WL: state <= ST_REV_WH;
        ST_REV_WH: begin
          lo <= lo + 1'b1;
          hi <= hi - 1'b1;
          if (32'(lo) + 32'd2 < 32'(hi)) begin
            state <= ST_REV_RL;
          end else begin
            // Reversal done: trace the other branch from the start pixel.
            cur_r      <= st_r;
            cur_c      <= st_c;
            probe      <= '0;
            pend_valid <= 1'b0;
            branch     <= 1'b1;
            state      <= ST_SCAN;
          end
        end
        ST_FINISH: begin
          // Hold until the result register is free.
          if (res_load) begin
            out_res.point_row   <= res_row;
            out_res.point_col   <= res_col;
            out_res.pixel_value <= res_pix;
            out_res.edge_length <= cl_ext[12:0];
            out_res.overflow    <= ovf;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  epct_ram #(.WIDTH(PIX_W), .DEPTH(NPIX)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  epct_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

endmodule

[design/epct_checker.sv]
// ----------------------------------------------------------------------------
// epct_checker
// Port-level checks for the edge pixel chain tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epct_checker #(
  parameter int MAX_POINTS = 4096
) (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input epct_pkg::in_t  in_req,
  input logic           out_valid,
  input logic           out_stall,
  input epct_pkg::out_t out_res
);
  import epct_pkg::*;

  localparam logic [12:0] LEN_FULL = 13'(MAX_POINTS % 8192);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_res), "result changed while stalled")
  `ASSERT_NEXT(a_one_request, in_valid && !in_stall, in_stall, "request accepted while busy")
  `ASSERT_ALWAYS(a_ovf_full, !(out_valid && out_res.overflow) || out_res.edge_length == LEN_FULL, "overflow without a full list")
  `ASSERT_ALWAYS(a_pix_range, !out_valid || out_res.pixel_value <= 12'sd1, "pixel value above one")

endmodule

bind edge_pixel_chain_tracker epct_checker #(.MAX_POINTS(MAX_POINTS)) u_epct_checker (.*);
